[rtl/core/prfc_pkg.sv]
// Port-rule flow classifier: shared types, widths and constants.
// Used by the bucket unit, way matcher and top level; depends on nothing else.
package prfc_pkg;

    localparam int BUCKETS_DEF = 4096;
    localparam int WAYS_DEF    = 4;

    localparam int HASH_W     = 24;
    localparam int HASH_MULT  = 13;
    localparam int NUM_PROBES = 3;
    localparam int WAY_IDX_W  = 4;

    localparam logic [6:0] CONF_HIT  = 7'd100;
    localparam logic [6:0] CONF_MISS = 7'd0;

    localparam logic KIND_INSERT   = 1'b0;
    localparam logic KIND_CLASSIFY = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  protocol;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic [15:0] rule_app;
        logic [7:0]  rule_subapp;
    } request_t;

    typedef struct packed {
        logic [15:0] app_found;
        logic [7:0]  subapp_found;
        logic [6:0]  confidence;
        logic        hit;
        logic        bucket_full;
        logic [31:0] hits_total;
        logic [31:0] misses_total;
    } result_t;

    typedef struct packed {
        logic        valid;
        logic [7:0]  protocol;
        logic [15:0] source_port;
        logic [15:0] destination_port;
    } key_t;

    typedef struct packed {
        logic [15:0] app;
        logic [7:0]  subapp;
    } value_t;

    localparam int KEY_W = $bits(key_t);
    localparam int VAL_W = $bits(value_t);

    typedef struct packed {
        logic load_hash;
        logic load_prod;
        logic load_rem;
    } bkt_ctrl_t;

    typedef struct packed {
        logic                 hit;
        logic [WAY_IDX_W-1:0] hit_way;
        logic                 free;
        logic [WAY_IDX_W-1:0] free_way;
    } match_t;

endpackage

[rtl/core/prfc_ram.sv]
// Generic single-port RAM with registered read data.
// Used for the key and value stores; no dependencies.
module prfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/prfc_bucket_unit.sv]
// Shared bucket index unit: key hash, then modulo BUCKETS by reciprocal
// multiply and one correcting subtract. Depends on prfc_pkg.
module prfc_bucket_unit #(
    parameter int BUCKETS = prfc_pkg::BUCKETS_DEF
) (
    input  logic                       aclk,
    input  prfc_pkg::bkt_ctrl_t        ctrl,
    input  logic [7:0]                 protocol,
    input  logic [15:0]                source_port,
    input  logic [15:0]                destination_port,
    output logic [$clog2(BUCKETS)-1:0] bucket
);

    import prfc_pkg::*;

    localparam int BKT_W   = $clog2(BUCKETS);
    localparam int RECIP   = (1 << HASH_W) / BUCKETS;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PROD_W  = HASH_W + RECIP_W;

    logic [HASH_W-1:0]  hash_reg;
    logic [HASH_W-1:0]  hash_next;
    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  prod_next;
    logic [BKT_W:0]     rem_reg;
    logic [BKT_W:0]     rem_next;
    logic [HASH_W-1:0]  quot_times_b;
    logic [HASH_W-1:0]  diff;

    assign hash_next = HASH_W'(protocol)
                     + HASH_W'(HASH_MULT) * (HASH_W'(source_port)
                     + HASH_W'(HASH_MULT) * HASH_W'(destination_port));

    assign prod_next    = PROD_W'(hash_reg) * PROD_W'(RECIP);
    assign quot_times_b = HASH_W'(prod_reg[PROD_W-1:HASH_W]) * HASH_W'(BUCKETS);
    assign diff         = hash_reg - quot_times_b;
    assign rem_next     = diff[BKT_W:0];

    assign bucket = (rem_reg >= (BKT_W+1)'(BUCKETS))
                  ? BKT_W'(rem_reg - (BKT_W+1)'(BUCKETS))
                  : rem_reg[BKT_W-1:0];

    always_ff @(posedge aclk) begin
        if (ctrl.load_hash) begin
            hash_reg <= hash_next;
        end
        if (ctrl.load_prod) begin
            prod_reg <= prod_next;
        end
        if (ctrl.load_rem) begin
            rem_reg <= rem_next;
        end
    end

endmodule

[rtl/core/prfc_way_match.sv]
// Way matcher: compares one bucket row against a probe key and finds the
// lowest matching way and the lowest free way. Depends on prfc_pkg.
module prfc_way_match #(
    parameter int WAYS = prfc_pkg::WAYS_DEF
) (
    input  logic [WAYS*prfc_pkg::KEY_W-1:0] key_row,
    input  prfc_pkg::key_t                  probe_key,
    output prfc_pkg::match_t                match
);

    import prfc_pkg::*;

    always_comb begin
        key_t way_key;
        match = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            way_key = key_row[w*KEY_W +: KEY_W];
            if (way_key == probe_key) begin
                match.hit     = 1'b1;
                match.hit_way = WAY_IDX_W'(w);
            end
            if (!way_key.valid) begin
                match.free     = 1'b1;
                match.free_way = WAY_IDX_W'(w);
            end
        end
    end

endmodule

[rtl/core/port_rule_flow_classifier_core.sv]
// Port-rule flow classifier top level: sequencer, rule table RAMs, counters.
// Depends on prfc_pkg, prfc_ram, prfc_bucket_unit and prfc_way_match.
//
//   channel   ports                       payload
//   request   s_valid s_ready s_data      prfc_pkg::request_t
//   result    m_valid m_ready m_data      prfc_pkg::result_t
//
// Each probe steps through the shared bucket unit and the row read: hash,
// reciprocal multiply, subtract, RAM address, way compare. Insert uses one
// probe; classify uses one to three and stops at the first hit. The block
// returns to idle before it accepts the next request. After reset a
// clearing pass writes every key row with s_ready low. A waiting result
// holds the compare step until m_ready.
module port_rule_flow_classifier_core #(
    parameter int BUCKETS = prfc_pkg::BUCKETS_DEF,
    parameter int WAYS    = prfc_pkg::WAYS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  prfc_pkg::request_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output prfc_pkg::result_t  m_data
);

    import prfc_pkg::*;

    localparam int BKT_W = $clog2(BUCKETS);
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int KROW_W = WAYS * KEY_W;
    localparam int VROW_W = WAYS * VAL_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_MUL,
        S_SUB,
        S_LOOK,
        S_CMP
    } state_t;

    state_t            state_reg, state_next;
    logic [BKT_W-1:0]  clr_cnt_reg, clr_cnt_next;
    request_t          item_reg, item_next;
    logic [1:0]        probe_reg, probe_next;
    logic [BKT_W-1:0]  bucket_reg, bucket_next;
    logic              m_valid_reg, m_valid_next;
    result_t           m_data_reg, m_data_next;
    logic [31:0]       hits_reg, hits_next;
    logic [31:0]       misses_reg, misses_next;

    bkt_ctrl_t         bkt_ctrl;
    logic [BKT_W-1:0]  bucket;
    key_t              probe_key;
    match_t            match;
    logic [WAY_W-1:0]  hit_way;
    logic [WAY_W-1:0]  free_way;
    logic [BKT_W-1:0]  ram_addr;
    logic              key_we;
    logic              val_we;
    logic [KROW_W-1:0] key_wdata;
    logic [KROW_W-1:0] key_rdata;
    logic [VROW_W-1:0] val_wdata;
    logic [VROW_W-1:0] val_rdata;
    value_t            hit_val;
    value_t            new_val;
    logic              out_free;

    assign probe_key.valid            = 1'b1;
    assign probe_key.protocol         = item_reg.protocol;
    assign probe_key.source_port      = (probe_reg == 2'd1) ? 16'd0 : item_reg.source_port;
    assign probe_key.destination_port = (probe_reg == 2'd2) ? 16'd0
                                                            : item_reg.destination_port;

    assign bkt_ctrl.load_hash = (state_reg == S_HASH);
    assign bkt_ctrl.load_prod = (state_reg == S_MUL);
    assign bkt_ctrl.load_rem  = (state_reg == S_SUB);

    prfc_bucket_unit #(
        .BUCKETS(BUCKETS)
    ) u_bucket (
        .aclk            (aclk),
        .ctrl            (bkt_ctrl),
        .protocol        (probe_key.protocol),
        .source_port     (probe_key.source_port),
        .destination_port(probe_key.destination_port),
        .bucket          (bucket)
    );

    prfc_ram #(
        .WIDTH(KROW_W),
        .DEPTH(BUCKETS)
    ) u_key_ram (
        .aclk (aclk),
        .we   (key_we),
        .addr (ram_addr),
        .wdata(key_wdata),
        .rdata(key_rdata)
    );

    prfc_ram #(
        .WIDTH(VROW_W),
        .DEPTH(BUCKETS)
    ) u_val_ram (
        .aclk (aclk),
        .we   (val_we),
        .addr (ram_addr),
        .wdata(val_wdata),
        .rdata(val_rdata)
    );

    prfc_way_match #(
        .WAYS(WAYS)
    ) u_match (
        .key_row  (key_rdata),
        .probe_key(probe_key),
        .match    (match)
    );

    assign hit_way  = match.hit_way[WAY_W-1:0];
    assign free_way = match.free_way[WAY_W-1:0];
    assign out_free = !m_valid_reg || m_ready;

    assign new_val.app    = item_reg.rule_app;
    assign new_val.subapp = item_reg.rule_subapp;

    always_comb begin
        hit_val   = '0;
        key_wdata = key_rdata;
        val_wdata = val_rdata;
        for (int w = 0; w < WAYS; w++) begin
            if (WAY_W'(w) == hit_way) begin
                hit_val = val_rdata[w*VAL_W +: VAL_W];
            end
            if (WAY_W'(w) == (match.hit ? hit_way : free_way)) begin
                key_wdata[w*KEY_W +: KEY_W] = probe_key;
                val_wdata[w*VAL_W +: VAL_W] = new_val;
            end
        end
        if (state_reg == S_CLEAR) begin
            key_wdata = '0;
        end
    end

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        item_next    = item_reg;
        probe_next   = probe_reg;
        bucket_next  = bucket_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        hits_next    = hits_reg;
        misses_next  = misses_reg;
        ram_addr     = bucket_reg;
        key_we       = 1'b0;
        val_we       = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                ram_addr     = clr_cnt_reg;
                key_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + BKT_W'(1);
                if (clr_cnt_reg == BKT_W'(BUCKETS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    probe_next = 2'd0;
                    state_next = S_HASH;
                end
            end
            S_HASH: begin
                state_next = S_MUL;
            end
            S_MUL: begin
                state_next = S_SUB;
            end
            S_SUB: begin
                state_next = S_LOOK;
            end
            S_LOOK: begin
                ram_addr    = bucket;
                bucket_next = bucket;
                state_next  = S_CMP;
            end
            S_CMP: begin
                m_data_next.app_found    = 16'd0;
                m_data_next.subapp_found = 8'd0;
                m_data_next.confidence   = CONF_MISS;
                m_data_next.hit          = 1'b0;
                m_data_next.bucket_full  = 1'b0;
                m_data_next.hits_total   = hits_reg;
                m_data_next.misses_total = misses_reg;
                if (item_reg.kind == KIND_INSERT) begin
                    if (out_free) begin
                        val_we                  = match.hit || match.free;
                        key_we                  = !match.hit && match.free;
                        m_data_next.bucket_full = !match.hit && !match.free;
                        m_valid_next            = 1'b1;
                        state_next              = S_IDLE;
                    end else begin
                        m_data_next = m_data_reg;
                    end
                end else if (match.hit) begin
                    if (out_free) begin
                        hits_next                = hits_reg + 32'd1;
                        m_data_next.app_found    = hit_val.app;
                        m_data_next.subapp_found = hit_val.subapp;
                        m_data_next.confidence   = CONF_HIT;
                        m_data_next.hit          = 1'b1;
                        m_data_next.hits_total   = hits_reg + 32'd1;
                        m_valid_next             = 1'b1;
                        state_next               = S_IDLE;
                    end else begin
                        m_data_next = m_data_reg;
                    end
                end else if (probe_reg == 2'(NUM_PROBES - 1)) begin
                    if (out_free) begin
                        misses_next              = misses_reg + 32'd1;
                        m_data_next.misses_total = misses_reg + 32'd1;
                        m_valid_next             = 1'b1;
                        state_next               = S_IDLE;
                    end else begin
                        m_data_next = m_data_reg;
                    end
                end else begin
                    m_data_next = m_data_reg;
                    probe_next  = probe_reg + 2'd1;
                    state_next  = S_HASH;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        bucket_reg <= bucket_next;
        m_data_reg <= m_data_next;
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            probe_reg   <= 2'd0;
            m_valid_reg <= 1'b0;
            hits_reg    <= 32'd0;
            misses_reg  <= 32'd0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            probe_reg   <= probe_next;
            m_valid_reg <= m_valid_next;
            hits_reg    <= hits_next;
            misses_reg  <= misses_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
